>>> design/decb_pkg.sv
`default_nettype none

package decb_pkg;

   // result status codes
   localparam logic [2:0] ST_DATA      = 3'd0;
   localparam logic [2:0] ST_MARKER    = 3'd1;
   localparam logic [2:0] ST_TRAILER   = 3'd2;
   localparam logic [2:0] ST_OVERSIZE  = 3'd3;
   localparam logic [2:0] ST_EARLY_END = 3'd4;

   // longest burst one input transaction can cause
   localparam int unsigned BURST_MAX = 19;
   localparam int unsigned CNT_W     = $clog2(BURST_MAX + 1);

   // bank-map record fields
   localparam logic [7:0] MAP_REG_A1  = 8'hA1;
   localparam logic [7:0] MAP_REG_A2  = 8'hA2;
   localparam logic [7:0] MAP_REG_A3  = 8'hA3;
   localparam logic [7:0] BANK_LOW    = 8'h04;
   localparam logic [7:0] BANK_A1_DEF = 8'h05;
   localparam logic [7:0] BANK_A2_DEF = 8'h06;
   localparam logic [7:0] BANK_A3_DEF = 8'h07;

   typedef struct packed {
      logic [7:0] data;
      logic [2:0] status;
   } decb_entry_type;

   typedef struct packed {
      logic [CNT_W-1:0]                    count;
      decb_entry_type [BURST_MAX-1:0]      entry;
   } decb_burst_type;

   // one byte of a six-byte bank-map record
   function automatic logic [7:0] map_byte(input logic [2:0] idx,
                                           input logic [7:0] reg_sel,
                                           input logic [7:0] bank);
      logic [7:0] res;
      case (idx)
         3'd0, 3'd1: res = 8'h00;
         3'd2:       res = 8'h01;
         3'd3:       res = 8'hFF;
         3'd4:       res = reg_sel;
         default:    res = bank;
      endcase
      return res;
   endfunction

   // one byte of the three start-up records, index 0..17
   function automatic logic [7:0] start_byte(input logic [4:0] idx);
      logic [7:0] res;
      if (idx < 5'd6) begin
         res = map_byte(idx[2:0], MAP_REG_A1, BANK_A1_DEF);
      end else if (idx < 5'd12) begin
         res = map_byte(3'(idx - 5'd6), MAP_REG_A2, BANK_A2_DEF);
      end else begin
         res = map_byte(3'(idx - 5'd12), MAP_REG_A3, BANK_A3_DEF);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

>>> design/decb_segment_relocator_top.sv
// Segment relocator: rewrites a segmented load image, one byte per
// request transaction.
// Request channel: req_tdata carries one image byte, req_tlast marks the
// end of the image (the byte is then ignored).
// Response channel: rsp_tdata carries an output byte, rsp_tuser a status
// code (0 data, 1 bad marker, 2 bad trailer, 3 oversized segment,
// 4 unexpected end), rsp_tlast flags the final response of one request.
// A request enters an input register and is decoded in the next cycle; its
// responses (0 to 19) are loaded into a shift queue once it can hold them,
// and leave one per cycle while the receiver is ready.
// Payload bytes sustain one request per cycle while the receiver is ready.
// A request that produces responses holds the next request until they drain
// through the single response port; requests with no responses skip the queue.
// Reset clears the phase and the start-up flag, so the three bank-map
// records go out again ahead of the first request's own responses.
// When the receiver stalls, the queue holds its head and the input
// register fills, after which req_tready drops. After an error response
// the block stays halted until reset.
`default_nettype none

module decb_segment_relocator_top
   import decb_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] in_byte
   input  wire logic       req_tlast,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_byte
   output logic [2:0]      rsp_tuser,   // [2:0] status
   output logic            rsp_tlast
);

   decb_burst_type burst;
   logic           burst_load;
   logic           queue_free;

   decb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_free (queue_free),
      .burst      (burst),
      .burst_load (burst_load)
   );

   decb_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .burst      (burst),
      .burst_load (burst_load),
      .queue_free (queue_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

>>> design/decb_ctrl.sv
`default_nettype none

module decb_ctrl
   import decb_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   input  wire logic [7:0]     req_tdata,
   input  wire logic           req_tlast,
   input  wire logic           queue_free,
   output decb_burst_type      burst,
   output logic                burst_load
);

   localparam logic [3:0] PH_MARKER   = 4'd0;
   localparam logic [3:0] PH_LEN_HI   = 4'd1;
   localparam logic [3:0] PH_LEN_LO   = 4'd2;
   localparam logic [3:0] PH_ADDR_HI  = 4'd3;
   localparam logic [3:0] PH_ADDR_LO  = 4'd4;
   localparam logic [3:0] PH_TRL_1    = 4'd5;
   localparam logic [3:0] PH_TRL_2    = 4'd6;
   localparam logic [3:0] PH_EXEC_HI  = 4'd7;
   localparam logic [3:0] PH_EXEC_LO  = 4'd8;
   localparam logic [3:0] PH_FINISHED = 4'd9;
   localparam logic [3:0] PH_PAYLOAD  = 4'd10;
   localparam logic [3:0] PH_HALTED   = 4'd11;

   localparam int unsigned START_LEN = 18;
   localparam int unsigned MAP_LEN   = 6;
   localparam int unsigned TAIL_MAX  = 5;

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff, in_byte_in;
   logic        in_eoi_ff, in_eoi_in;

   // block state
   logic [3:0]  phase_ff, phase_in;
   logic        started_ff, started_in;
   logic        low_bank_ff, low_bank_in;
   logic [15:0] seg_len_ff, seg_len_in;
   logic [7:0]  load_hi_ff, load_hi_in;
   logic [7:0]  exec_hi_ff, exec_hi_in;

   // burst description
   logic                 map_en;
   logic [7:0]           map_bank;
   logic [2:0]           tail_n;
   logic [2:0]           tail_st;
   logic [TAIL_MAX-1:0][7:0] tail;
   logic [7:0]           addr_hi_adj;
   logic [16:0]          seg_end;
   logic                 step;

   // decode one transaction against the current phase
   always_comb begin
      phase_in    = phase_ff;
      started_in  = 1'b1;
      low_bank_in = low_bank_ff;
      seg_len_in  = seg_len_ff;
      load_hi_in  = load_hi_ff;
      exec_hi_in  = exec_hi_ff;
      map_en      = 1'b0;
      map_bank    = BANK_A1_DEF;
      tail_n      = 3'd0;
      tail_st     = ST_DATA;
      tail        = '0;
      addr_hi_adj = (in_byte_ff < 8'h20) ? in_byte_ff + 8'h20 : in_byte_ff;
      seg_end     = {1'b0, load_hi_ff, in_byte_ff} + {1'b0, seg_len_ff};

      if (in_eoi_ff) begin
         if (phase_ff != PH_FINISHED && phase_ff != PH_HALTED) begin
            tail_n   = 3'd1;
            tail_st  = ST_EARLY_END;
            phase_in = PH_HALTED;
         end
      end else begin
         unique case (phase_ff)
            PH_MARKER: begin
               if (in_byte_ff == 8'hFF) begin
                  phase_in = PH_TRL_1;
               end else if (in_byte_ff == 8'h00) begin
                  phase_in = PH_LEN_HI;
               end else begin
                  tail_n   = 3'd1;
                  tail_st  = ST_MARKER;
                  phase_in = PH_HALTED;
               end
            end
            PH_TRL_1, PH_TRL_2: begin
               if (in_byte_ff != 8'h00) begin
                  tail_n   = 3'd1;
                  tail_st  = ST_TRAILER;
                  phase_in = PH_HALTED;
               end else begin
                  phase_in = (phase_ff == PH_TRL_1) ? PH_TRL_2 : PH_EXEC_HI;
               end
            end
            PH_EXEC_HI: begin
               exec_hi_in = in_byte_ff;
               phase_in   = PH_EXEC_LO;
            end
            PH_EXEC_LO: begin
               tail_n   = 3'd5;
               tail     = {in_byte_ff, exec_hi_ff, 8'h00, 8'h00, 8'hFF};
               phase_in = PH_FINISHED;
            end
            PH_LEN_HI: begin
               seg_len_in = {in_byte_ff, 8'h00};
               phase_in   = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               seg_len_in = {seg_len_ff[15:8], in_byte_ff};
               phase_in   = PH_ADDR_HI;
            end
            PH_ADDR_HI: begin
               // shift low loads up and switch the bank map on mode change
               if (in_byte_ff < 8'h20) begin
                  if (!low_bank_ff) begin
                     map_en      = 1'b1;
                     map_bank    = BANK_LOW;
                     low_bank_in = 1'b1;
                  end
               end else if (low_bank_ff) begin
                  map_en      = 1'b1;
                  map_bank    = BANK_A1_DEF;
                  low_bank_in = 1'b0;
               end
               load_hi_in = addr_hi_adj;
               phase_in   = PH_ADDR_LO;
            end
            PH_ADDR_LO: begin
               if (seg_end[16]) begin
                  tail_n   = 3'd1;
                  tail_st  = ST_OVERSIZE;
                  phase_in = PH_HALTED;
               end else begin
                  tail_n   = 3'd5;
                  tail     = {in_byte_ff, load_hi_ff, seg_len_ff[7:0],
                              seg_len_ff[15:8], 8'h00};
                  phase_in = (seg_len_ff == 16'd0) ? PH_MARKER : PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               tail_n     = 3'd1;
               tail[0]    = in_byte_ff;
               seg_len_in = seg_len_ff - 16'd1;
               if (seg_len_ff == 16'd1) begin
                  phase_in = PH_MARKER;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // lay out the burst: start records, bank-map record, then the tail
   always_comb begin
      burst.count = (started_ff ? CNT_W'(0) : CNT_W'(START_LEN))
                  + (map_en ? CNT_W'(MAP_LEN) : CNT_W'(0))
                  + CNT_W'(tail_n);
      for (int i = 0; i < BURST_MAX; i++) begin
         burst.entry[i] = '0;
         if (!started_ff) begin
            if (i < START_LEN) begin
               burst.entry[i].data = start_byte(CNT_W'(i));
            end else if (i == START_LEN) begin
               burst.entry[i].data   = tail[0];
               burst.entry[i].status = tail_st;
            end
         end else if (map_en) begin
            if (i < MAP_LEN) begin
               burst.entry[i].data = map_byte(3'(i), MAP_REG_A1, map_bank);
            end else if (i < MAP_LEN + TAIL_MAX) begin
               burst.entry[i].data   = tail[i - MAP_LEN];
               burst.entry[i].status = tail_st;
            end
         end else if (i < TAIL_MAX) begin
            burst.entry[i].data   = tail[i];
            burst.entry[i].status = tail_st;
         end
      end
   end

   // take the transaction once the result queue can hold its burst, or at once if the burst is empty
   assign step       = in_valid_ff && (queue_free || burst.count == '0);
   assign burst_load = step && burst.count != '0;
   assign req_tready = !in_valid_ff || step;

   always_comb begin
      in_valid_in = in_valid_ff && !step;
      in_byte_in  = in_byte_ff;
      in_eoi_in   = in_eoi_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
         in_eoi_in   = req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_eoi_ff  <= in_eoi_in;
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= PH_MARKER;
         started_ff  <= 1'b0;
         low_bank_ff <= 1'b0;
         seg_len_ff  <= '0;
         load_hi_ff  <= '0;
         exec_hi_ff  <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (step) begin
            phase_ff    <= phase_in;
            started_ff  <= started_in;
            low_bank_ff <= low_bank_in;
            seg_len_ff  <= seg_len_in;
            load_hi_ff  <= load_hi_in;
            exec_hi_ff  <= exec_hi_in;
         end
      end
   end

endmodule

`default_nettype wire

>>> design/decb_outq.sv
`default_nettype none

module decb_outq
   import decb_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire decb_burst_type burst,
   input  wire logic           burst_load,
   output logic                queue_free,
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   output logic [7:0]          rsp_tdata,
   output logic [2:0]          rsp_tuser,
   output logic                rsp_tlast
);

   decb_entry_type [BURST_MAX-1:0] entry_ff, entry_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic                           pop;

   assign rsp_tvalid = cnt_ff != '0;
   assign rsp_tdata  = entry_ff[0].data;
   assign rsp_tuser  = entry_ff[0].status;
   assign rsp_tlast  = cnt_ff == CNT_W'(1);
   assign pop        = rsp_tvalid && rsp_tready;
   assign queue_free = cnt_ff == '0 || (rsp_tlast && pop);

   // load a fresh burst or shift the head out
   always_comb begin
      entry_in = entry_ff;
      cnt_in   = cnt_ff;
      if (burst_load) begin
         entry_in = burst.entry;
         cnt_in   = burst.count;
      end else if (pop) begin
         for (int i = 0; i < BURST_MAX - 1; i++) begin
            entry_in[i] = entry_ff[i + 1];
         end
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

>>> design/decb_chk.sv
`default_nettype none

module decb_chk
   import decb_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic [2:0] rsp_tuser,
   input wire logic       rsp_tlast
);

   logic halted_ff, halted_in;

   // remember that an error response has gone out
   assign halted_in = halted_ff || (rsp_tvalid && rsp_tready && rsp_tuser != ST_DATA);

   always_ff @(posedge clock) begin
      if (reset) begin
         halted_ff <= 1'b0;
      end else begin
         halted_ff <= halted_in;
      end
   end

   // an error response carries a zero byte and ends its burst
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_DATA |-> rsp_tdata == 8'h00 && rsp_tlast)
      else $error("error response with data or not last");

   // status stays within the defined codes
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == ST_DATA || rsp_tuser == ST_MARKER
                  || rsp_tuser == ST_TRAILER || rsp_tuser == ST_OVERSIZE
                  || rsp_tuser == ST_EARLY_END)
      else $error("undefined status code");

   // nothing follows an error response
   a_halt_quiet: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> !rsp_tvalid)
      else $error("response after halt");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // with nothing queued and the input free, req_tready is always high
   a_req_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !$past(req_tvalid && req_tready) && !$past(rsp_tvalid)
      && !$past(reset) |-> req_tready)
      else $error("request refused while idle");

endmodule

bind decb_segment_relocator_top decb_chk u_decb_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

>>> sim/tb_decb_segment_relocator_top.sv
`timescale 1ns / 100ps

import decb_pkg::*;

// image framing bytes
localparam logic [7:0] SEG_MARKER     = 8'h00;
localparam logic [7:0] TRAILER_MARKER = 8'hFF;
localparam logic [7:0] LOW_LIMIT      = 8'h20;   // load pages below this get shifted up
localparam logic [7:0] MAP_LEAD       = 8'h01;   // third byte of a bank-map record

// Keeps its own copy of the relocator state and the queue of output bytes
// still owed by the block.
class relocation_scoreboard;
   typedef enum logic [3:0] {
      AWAIT_MARKER, LEN_HI, LEN_LO, ADDR_HI, ADDR_LO,
      TRAILER_1, TRAILER_2, EXEC_HI, EXEC_LO, DONE, PAYLOAD, HALTED
   } image_phase_t;

   typedef struct packed {
      logic [7:0] data;
      logic [2:0] status;
      logic       last;
   } out_byte_t;

   out_byte_t    expected_bytes[$];
   int unsigned  failures;

   image_phase_t phase;
   bit           started;
   bit           low_mapped;
   logic [15:0]  seg_len;
   logic [7:0]   load_hi;
   logic [7:0]   exec_hi;
   out_byte_t    burst[$];

   function new();
      phase      = AWAIT_MARKER;
      started    = 1'b0;
      low_mapped = 1'b0;
      seg_len    = '0;
      load_hi    = '0;
      exec_hi    = '0;
      failures   = 0;
   endfunction

   // append one byte to the burst of the current transaction
   function void emit(logic [7:0] b, logic [2:0] st);
      out_byte_t e;
      if (burst.size() < BURST_MAX) begin
         e.data   = b;
         e.status = st;
         e.last   = 1'b0;
         burst.push_back(e);
      end
   endfunction

   function void emit_map(logic [7:0] reg_sel, logic [7:0] bank);
      emit(8'h00, ST_DATA);
      emit(8'h00, ST_DATA);
      emit(MAP_LEAD, ST_DATA);
      emit(TRAILER_MARKER, ST_DATA);
      emit(reg_sel, ST_DATA);
      emit(bank, ST_DATA);
   endfunction

   function void halt(logic [2:0] code);
      emit(8'h00, code);
      phase = HALTED;
   endfunction

   // Work out the output bytes that one accepted input transaction causes.
   function void relocate_byte(logic [7:0] b, logic eoi);
      logic [16:0] span;
      logic [7:0]  page;
      burst.delete();

      // start-up records precede everything else
      if (!started) begin
         emit_map(MAP_REG_A1, BANK_A1_DEF);
         emit_map(MAP_REG_A2, BANK_A2_DEF);
         emit_map(MAP_REG_A3, BANK_A3_DEF);
         started = 1'b1;
      end

      if (eoi) begin
         if (phase != DONE && phase != HALTED) begin
            halt(ST_EARLY_END);
         end
      end else begin
         case (phase)
            AWAIT_MARKER: begin
               if (b == TRAILER_MARKER) begin
                  phase = TRAILER_1;
               end else if (b == SEG_MARKER) begin
                  phase = LEN_HI;
               end else begin
                  halt(ST_MARKER);
               end
            end
            TRAILER_1: begin
               if (b != 8'h00) halt(ST_TRAILER);
               else phase = TRAILER_2;
            end
            TRAILER_2: begin
               if (b != 8'h00) halt(ST_TRAILER);
               else phase = EXEC_HI;
            end
            EXEC_HI: begin
               exec_hi = b;
               phase   = EXEC_LO;
            end
            EXEC_LO: begin
               emit(TRAILER_MARKER, ST_DATA);
               emit(8'h00, ST_DATA);
               emit(8'h00, ST_DATA);
               emit(exec_hi, ST_DATA);
               emit(b, ST_DATA);
               phase = DONE;
            end
            LEN_HI: begin
               seg_len = {b, 8'h00};
               phase   = LEN_LO;
            end
            LEN_LO: begin
               seg_len[7:0] = b;
               phase        = ADDR_HI;
            end
            ADDR_HI: begin
               page = b;
               // shift low pages and switch the bank map on mode changes
               if (b < LOW_LIMIT) begin
                  page = b + LOW_LIMIT;
                  if (!low_mapped) begin
                     emit_map(MAP_REG_A1, BANK_LOW);
                     low_mapped = 1'b1;
                  end
               end else if (low_mapped) begin
                  emit_map(MAP_REG_A1, BANK_A1_DEF);
                  low_mapped = 1'b0;
               end
               load_hi = page;
               phase   = ADDR_LO;
            end
            ADDR_LO: begin
               span = {1'b0, load_hi, b} + {1'b0, seg_len};
               if (span > 17'h0FFFF) begin
                  halt(ST_OVERSIZE);
               end else begin
                  emit(SEG_MARKER, ST_DATA);
                  emit(seg_len[15:8], ST_DATA);
                  emit(seg_len[7:0], ST_DATA);
                  emit(load_hi, ST_DATA);
                  emit(b, ST_DATA);
                  if (seg_len == 16'd0) phase = AWAIT_MARKER;
                  else phase = PAYLOAD;
               end
            end
            PAYLOAD: begin
               emit(b, ST_DATA);
               seg_len = seg_len - 16'd1;
               if (seg_len == 16'd0) phase = AWAIT_MARKER;
            end
            default: begin
            end
         endcase
      end

      if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) expected_bytes.push_back(burst[i]);
   endfunction

   // Compare one accepted output transaction with the oldest expected byte.
   function void check_output_byte(logic [7:0] data, logic [2:0] status, logic last);
      out_byte_t want;
      if (expected_bytes.size() == 0) begin
         failures++;
         if (failures <= 10) begin
            $display("%0t: unexpected output: data %h status %0d last %b",
                     $realtime, data, status, last);
         end
         return;
      end
      want = expected_bytes.pop_front();
      if (want.data !== data || want.status !== status || want.last !== last) begin
         failures++;
         if (failures <= 10) begin
            $display("%0t: mismatch: expected data %h status %0d last %b, got data %h status %0d last %b",
                     $realtime, want.data, want.status, want.last, data, status, last);
         end
      end
   endfunction
endclass

module tb_decb_segment_relocator_top;
   typedef enum {
      END_TRAILER, END_BAD_MARKER, END_BAD_TRAILER_2, END_BAD_TRAILER_3,
      END_OVERSIZE, END_EARLY
   } image_end_t;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic       rsp_tlast;

   relocation_scoreboard image_sb;
   int unsigned          items_sent = 0;
   bit                   hold_request = 1'b0;
   logic                 quiet;

   // both sides run without idling across this stretch of the image
   assign quiet = (items_sent >= 100) && (items_sent < 180);

   decb_segment_relocator_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // check every output transaction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         image_sb.check_output_byte(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin : receiver
      int unsigned hold_cycles;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            for (hold_cycles = 0; hold_cycles < 200; hold_cycles++) @(negedge clock);
         end
         rsp_tready <= !reset && (quiet || $urandom_range(99) >= 25);
      end
   end

   // Offer one image byte, starting and ending at a falling edge.
   task automatic send_item(input logic [7:0] b, input logic eoi);
      while (!quiet && $urandom_range(99) < 25) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eoi;
      do @(posedge clock); while (!req_tready);
      image_sb.relocate_byte(b, eoi);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_segment(input logic [15:0] len, input logic [7:0] hi,
                               input logic [7:0] lo);
      send_item(SEG_MARKER, 1'b0);
      send_item(len[15:8], 1'b0);
      send_item(len[7:0], 1'b0);
      send_item(hi, 1'b0);
      send_item(lo, 1'b0);
      for (int unsigned i = 0; i < len; i++) send_item(8'($urandom), 1'b0);
   endtask

   // Well-formed segment that stays inside the address space.
   task automatic send_random_segment();
      logic [15:0] len;
      logic [7:0]  hi;
      logic [7:0]  lo;
      int unsigned start;
      if ($urandom_range(7) == 0) len = 16'd0;
      else if ($urandom_range(15) == 0) len = 16'($urandom_range(13, 40));
      else len = 16'($urandom_range(1, 12));
      if ($urandom_range(99) < 40) hi = 8'($urandom_range(8'h1F));
      else hi = 8'($urandom);
      lo = 8'($urandom);
      start = (hi < LOW_LIMIT) ? (int'(hi) + int'(LOW_LIMIT)) * 256 + int'(lo)
                               : int'(hi) * 256 + int'(lo);
      if (start + int'(len) > 65535) begin
         hi = 8'hE0;
         lo = 8'h00;
      end
      send_segment(len, hi, lo);
   endtask

   initial begin : stimulus
      image_end_t  ending;
      int unsigned prefix;
      bit          hold_done;
      logic [7:0]  early_seq [0:6];

      image_sb   = new();
      hold_done  = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tlast  = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: enter shifted mode, stay in it, leave it, top of memory
      send_segment(16'd3, 8'h1F, 8'h00);
      send_segment(16'd0, 8'h00, 8'h00);
      send_segment(16'd2, 8'h20, 8'hFE);
      send_segment(16'd0, 8'hFF, 8'hFF);

      // random well-formed segments; one long receiver hold-off midway
      while (items_sent < 395) begin
         if (!hold_done && items_sent >= 220) begin
            hold_request = 1'b1;
            hold_done    = 1'b1;
         end
         send_random_segment();
      end

      // finish the image in one of the ways that stop the block
      ending = image_end_t'($urandom_range(5));
      case (ending)
         END_TRAILER: begin
            send_item(TRAILER_MARKER, 1'b0);
            send_item(8'h00, 1'b0);
            send_item(8'h00, 1'b0);
            send_item(8'($urandom), 1'b0);
            send_item(8'($urandom), 1'b0);
            send_item(8'($urandom), 1'b1);
         end
         END_BAD_MARKER: begin
            send_item(8'($urandom_range(8'h01, 8'hFE)), 1'b0);
         end
         END_BAD_TRAILER_2: begin
            send_item(TRAILER_MARKER, 1'b0);
            send_item(8'($urandom_range(8'h01, 8'hFF)), 1'b0);
         end
         END_BAD_TRAILER_3: begin
            send_item(TRAILER_MARKER, 1'b0);
            send_item(8'h00, 1'b0);
            send_item(8'($urandom_range(8'h01, 8'hFF)), 1'b0);
         end
         END_OVERSIZE: begin
            // length of at least 0xE000 cannot fit above a shifted page
            send_item(SEG_MARKER, 1'b0);
            send_item(8'($urandom_range(8'hE0, 8'hFF)), 1'b0);
            send_item(8'($urandom), 1'b0);
            send_item(8'($urandom), 1'b0);
            send_item(8'($urandom), 1'b0);
         end
         default: begin
            // cut the image short before or inside a segment, or inside the trailer
            if ($urandom_range(1) == 0) begin
               early_seq = '{SEG_MARKER, 8'h00, 8'h03, 8'h40, 8'($urandom),
                             8'($urandom), 8'($urandom)};
               prefix = $urandom_range(0, 6);
            end else begin
               early_seq = '{TRAILER_MARKER, 8'h00, 8'h00, 8'($urandom),
                             8'h00, 8'h00, 8'h00};
               prefix = $urandom_range(1, 4);
            end
            for (int unsigned i = 0; i < prefix; i++) send_item(early_seq[i], 1'b0);
            send_item(8'($urandom), 1'b1);
         end
      endcase

      // the block has stopped: these must produce nothing
      for (int unsigned i = 0; i < 4; i++) send_item(8'($urandom), 1'($urandom));
      req_tvalid <= 1'b0;

      // drain, then allow for anything stray
      while (image_sb.expected_bytes.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (image_sb.failures == 0 && image_sb.expected_bytes.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
